// File: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// File: hdl/isl_pkg.sv
// ---------------------------------------------------------------------------
// isl_pkg
// Types and constants shared by the indexed shift list modules.
// ---------------------------------------------------------------------------
`default_nettype none

package isl_pkg;

   // List capacity and derived widths
   localparam int CAPACITY = 16;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int POS_W    = 5;
   localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int WORD_W   = 32;
   localparam int OUT_CNT_W = 5;

   // Operation codes
   typedef enum logic [2:0] {
      OP_PUSH   = 3'd0,
      OP_INSERT = 3'd1,
      OP_POP    = 3'd2,
      OP_DELETE = 3'd3,
      OP_READ   = 3'd4
   } op_type;

   // Result status codes
   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2,
      STAT_RANGE = 2'd3
   } status_type;

   // Controller states
   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic capture;
      logic execute;
   } cmd_type;

endpackage

`default_nettype wire

// File: hdl/indexed_shift_list.sv
// ---------------------------------------------------------------------------
// indexed_shift_list
// Fixed-capacity ordered list of signed words with push, insert, pop,
// delete and read, built as a controller and a shift-chain datapath.
// ---------------------------------------------------------------------------
// A request is transferred at a clock edge with start high and busy low.
// The list executes it in the following cycle, with busy high, and all
// shifting entries of the chain move in that cycle; the result is shown on
// the rsp_ ports for exactly one cycle with rsp_valid high, starting in the
// cycle after execution. The receiver cannot stall: sample the result when
// rsp_valid is high. A new request may be transferred in the cycle the
// result is shown, but not while busy is high in the controller's single
// execute state. There is no clearing pass after reset; entries at or above
// the count are never read.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module indexed_shift_list (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic [2:0]                         req_operation,
   input  wire logic [isl_pkg::POS_W-1:0]          req_position,
   input  wire logic signed [isl_pkg::WORD_W-1:0]  req_data_word,
   output logic                                    rsp_valid,
   output logic signed [isl_pkg::WORD_W-1:0]       rsp_read_word,
   output logic [isl_pkg::OUT_CNT_W-1:0]           rsp_entry_count,
   output logic                                    rsp_is_full,
   output logic                                    rsp_is_empty,
   output logic [1:0]                              rsp_status
);

   isl_pkg::cmd_type cmd;

   // Sequencer
   isl_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   // Shift chain and result register
   isl_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_operation   (req_operation),
      .req_position    (req_position),
      .req_data_word   (req_data_word),
      .rsp_valid       (rsp_valid),
      .rsp_read_word   (rsp_read_word),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_full     (rsp_is_full),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_status      (rsp_status)
   );

   // A transferred request always runs its execute cycle next
   `ASSERT_NEXT(a_start_exec, clock, reset, start && !busy, busy && cmd.execute)
   // Every execute cycle is followed by exactly one result strobe
   `ASSERT_NEXT(a_exec_rsp, clock, reset, cmd.execute, rsp_valid)
   // The result shows while the sequencer is free again
   `ASSERT_IMPLIES(a_rsp_idle, clock, reset, rsp_valid, !busy && !cmd.execute)
   // A list cannot be full and empty at once
   `ASSERT_IMPLIES(a_flags, clock, reset, rsp_valid, !(rsp_is_full && rsp_is_empty))

endmodule

`default_nettype wire

// File: hdl/isl_ctrl.sv
// ---------------------------------------------------------------------------
// isl_ctrl
// Sequencer: capture a request, then run one execute cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module isl_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   output isl_pkg::cmd_type      cmd
);

   isl_pkg::state_type state_ff;
   isl_pkg::state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= isl_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      busy        = 1'b0;
      case (state_ff)
         isl_pkg::ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = isl_pkg::ST_EXEC;
            end
         end
         isl_pkg::ST_EXEC: begin
            busy        = 1'b1;
            cmd.execute = 1'b1;
            state_in    = isl_pkg::ST_IDLE;
         end
         default: begin
            state_in = isl_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: hdl/isl_datapath.sv
// ---------------------------------------------------------------------------
// isl_datapath
// Entry shift chain, count register, request capture and result register.
// ---------------------------------------------------------------------------
`default_nettype none

module isl_datapath (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire isl_pkg::cmd_type                   cmd,
   input  wire logic [2:0]                         req_operation,
   input  wire logic [isl_pkg::POS_W-1:0]          req_position,
   input  wire logic signed [isl_pkg::WORD_W-1:0]  req_data_word,
   output logic                                    rsp_valid,
   output logic signed [isl_pkg::WORD_W-1:0]       rsp_read_word,
   output logic [isl_pkg::OUT_CNT_W-1:0]           rsp_entry_count,
   output logic                                    rsp_is_full,
   output logic                                    rsp_is_empty,
   output logic [1:0]                              rsp_status
);

   localparam int CAP = isl_pkg::CAPACITY;
   localparam int CW  = isl_pkg::CNT_W;
   localparam int IW  = isl_pkg::IDX_W;
   localparam int MW  = isl_pkg::CMP_W;
   localparam int WW  = isl_pkg::WORD_W;

   // Captured request
   logic [2:0]                  op_ff;
   logic [isl_pkg::POS_W-1:0]   pos_ff;
   logic [WW-1:0]               word_ff;

   // List state
   logic [WW-1:0]               entries_ff [CAP];
   logic [CW-1:0]               count_ff;
   logic [CW-1:0]               count_in;

   // Result register
   logic                        rsp_valid_ff;
   logic [WW-1:0]               rsp_word_ff;
   logic [isl_pkg::OUT_CNT_W-1:0] rsp_count_ff;
   logic                        rsp_full_ff;
   logic                        rsp_empty_ff;
   logic [1:0]                  rsp_status_ff;

   // Execute-cycle decode
   logic [WW-1:0]               up_word [CAP];
   logic [WW-1:0]               dn_word [CAP];
   logic [MW-1:0]               pos_cmp;
   logic [MW-1:0]               cnt_cmp;
   logic [MW-1:0]               shift_pos;
   logic [IW-1:0]               rd_idx;
   logic [WW-1:0]               rd_word;
   logic                        list_full;
   logic                        list_empty;
   logic                        do_ins;
   logic                        do_del;
   logic [WW-1:0]               result;
   isl_pkg::status_type         status;

   // Hold the request
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_operation;
         pos_ff  <= req_position;
         word_ff <= req_data_word;
      end
   end

   // Neighbor taps of the shift chain
   for (genvar g = 0; g < CAP; g++) begin : g_taps
      if (g == 0) begin : g_first
         assign up_word[g] = word_ff;
      end else begin : g_rest_up
         assign up_word[g] = entries_ff[g-1];
      end
      if (g == CAP - 1) begin : g_last
         assign dn_word[g] = entries_ff[g];
      end else begin : g_rest_dn
         assign dn_word[g] = entries_ff[g+1];
      end
   end

   assign pos_cmp    = MW'(pos_ff);
   assign cnt_cmp    = MW'(count_ff);
   assign list_full  = (count_ff == CW'(CAP));
   assign list_empty = (count_ff == '0);

   // Single read port: pop reads the last entry, read uses the index
   assign rd_idx  = (op_ff == isl_pkg::OP_POP) ? IW'(count_ff - CW'(1)) : IW'(pos_ff);
   assign rd_word = entries_ff[rd_idx];

   // Decode the operation
   always_comb begin
      count_in  = count_ff;
      do_ins    = 1'b0;
      do_del    = 1'b0;
      shift_pos = pos_cmp;
      result    = '0;
      status    = isl_pkg::STAT_OK;
      case (op_ff)
         isl_pkg::OP_PUSH: begin
            if (list_full) begin
               status = isl_pkg::STAT_FULL;
            end else begin
               do_ins    = 1'b1;
               shift_pos = cnt_cmp;
               count_in  = count_ff + CW'(1);
            end
         end
         isl_pkg::OP_INSERT: begin
            if (list_full) begin
               status = isl_pkg::STAT_FULL;
            end else if (pos_cmp > cnt_cmp) begin
               status = isl_pkg::STAT_RANGE;
            end else begin
               do_ins   = 1'b1;
               count_in = count_ff + CW'(1);
            end
         end
         isl_pkg::OP_POP: begin
            if (list_empty) begin
               status = isl_pkg::STAT_EMPTY;
            end else begin
               result   = rd_word;
               count_in = count_ff - CW'(1);
            end
         end
         isl_pkg::OP_DELETE: begin
            if (pos_cmp >= cnt_cmp) begin
               status = isl_pkg::STAT_RANGE;
            end else begin
               do_del   = 1'b1;
               count_in = count_ff - CW'(1);
            end
         end
         isl_pkg::OP_READ: begin
            if (pos_cmp >= cnt_cmp) begin
               status = isl_pkg::STAT_RANGE;
            end else begin
               result = rd_word;
            end
         end
         default: begin
         end
      endcase
   end

   // Advance the shift chain: all shifting entries move in the same cycle
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         for (int i = 0; i < CAP; i++) begin
            if (do_ins && (MW'(i) == shift_pos)) begin
               entries_ff[i] <= word_ff;
            end else if (do_ins && (MW'(i) > shift_pos)) begin
               entries_ff[i] <= up_word[i];
            end else if (do_del && (MW'(i) >= shift_pos)) begin
               entries_ff[i] <= dn_word[i];
            end
         end
      end
   end

   // Count and result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.execute;
         if (cmd.execute) begin
            count_ff <= count_in;
         end
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         rsp_word_ff   <= result;
         rsp_count_ff  <= isl_pkg::OUT_CNT_W'(count_in);
         rsp_full_ff   <= (count_in == CW'(CAP));
         rsp_empty_ff  <= (count_in == '0);
         rsp_status_ff <= status;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_word   = rsp_word_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_is_full     = rsp_full_ff;
   assign rsp_is_empty    = rsp_empty_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

`default_nettype wire
